// ===== rtl/ipv6tc_pkg.sv =====
// ----------------------------------------------------------------------------
// IPv6 text compressor package
// Shared payload types, queue entry type and character constants.
// ----------------------------------------------------------------------------
package ipv6tc_pkg;

  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } in_data_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last_char;
  } out_data_t;

  // One classified address: the zero run to print as "::", if there is one.
  typedef struct packed {
    logic [127:0] addr;
    logic [2:0]   run_lo;
    logic [2:0]   run_hi;
    logic         has_run;
  } entry_t;

  localparam logic [6:0] CHR_ZERO  = 7'd48;
  localparam logic [6:0] CHR_A     = 7'd97;
  localparam logic [6:0] CHR_COLON = 7'd58;

endpackage

// ===== rtl/ipv6tc_front.sv =====
// ----------------------------------------------------------------------------
// IPv6 text compressor front end
// Finds the zero run whose "::" form gives the shortest, smallest text.
// ----------------------------------------------------------------------------
module ipv6tc_front import ipv6tc_pkg::*; (
  input  logic     in_valid,
  input  in_data_t in_data,
  input  logic     q_full,
  output logic     in_stall,
  output logic     push,
  output entry_t   push_entry
);

  logic [127:0] addr;
  logic [3:0]   run_len;
  logic [2:0]   run_start;
  logic [4:0]   best_score;
  logic [4:0]   score;
  logic [2:0]   best_lo;
  logic [2:0]   best_hi;
  logic         have;
  logic         zero;

  assign addr = {in_data.addr_high, in_data.addr_low};

  // Compressing a run of L groups saves 2L-1 characters, one less at either
  // end of the address. On a tie the later run wins: its text has a digit
  // where the earlier candidate has a colon, and digits sort lower.
  always_comb begin
    run_len    = 4'd0;
    run_start  = 3'd0;
    best_score = 5'd0;
    best_lo    = 3'd0;
    best_hi    = 3'd0;
    have       = 1'b0;
    score      = 5'd0;
    zero       = 1'b0;
    for (int i = 0; i < 9; i++) begin
      zero = (i < 8) && (addr[(7 - (i % 8)) * 16 +: 16] == 16'd0);
      if (zero) begin
        if (run_len == 4'd0) begin
          run_start = 3'(i);
        end
        run_len = run_len + 4'd1;
      end else begin
        if (run_len >= 4'd2) begin
          score = {run_len, 1'b0} - 5'd1 - 5'(run_start == 3'd0) - 5'(i == 8);
          if (!have || score >= best_score) begin
            best_score = score;
            best_lo    = run_start;
            best_hi    = 3'(i - 1);
            have       = 1'b1;
          end
        end
        run_len = 4'd0;
      end
    end
  end

  assign in_stall           = q_full;
  assign push               = in_valid && !q_full;
  assign push_entry.addr    = addr;
  assign push_entry.run_lo  = best_lo;
  assign push_entry.run_hi  = best_hi;
  assign push_entry.has_run = have;

endmodule

// ===== rtl/ipv6tc_queue.sv =====
// ----------------------------------------------------------------------------
// IPv6 text compressor queue
// Two-entry queue between the classifier and the character sequencer.
// ----------------------------------------------------------------------------
module ipv6tc_queue import ipv6tc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t pop_entry,
  output logic   q_full,
  output logic   q_empty
);

  entry_t     mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  assign pop_entry = mem_r[rd_ptr_r];
  assign q_full    = count_r == 2'd2;
  assign q_empty   = count_r == 2'd0;

endmodule

// ===== rtl/ipv6tc_back.sv =====
// ----------------------------------------------------------------------------
// IPv6 text compressor back end
// Walks groups and nibbles of one address and sends one character a cycle while out_stall is low.
// ----------------------------------------------------------------------------
module ipv6tc_back import ipv6tc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  entry_t    pop_entry,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_data_t out_data
);

  typedef enum logic [1:0] {PH_DIG, PH_COL, PH_DC1, PH_DC2} phase_t;

  phase_t     ph_r, ph_nxt;
  entry_t     ent_r;
  logic [2:0] g_r, g_nxt;
  logic [1:0] n_r, n_nxt;
  logic       busy_r, busy_nxt;
  logic       out_valid_r;
  out_data_t  out_data_r, out_data_nxt;
  logic       adv;
  logic [15:0] grp;
  logic [3:0]  nib;
  logic [2:0]  g_inc;
  logic [2:0]  hi_inc;

  function automatic logic [1:0] first_nib(input logic [15:0] v);
    logic [1:0] r;
    r = 2'd3;
    if (v[15:12] != 4'd0) begin
      r = 2'd0;
    end else if (v[11:8] != 4'd0) begin
      r = 2'd1;
    end else if (v[7:4] != 4'd0) begin
      r = 2'd2;
    end
    return r;
  endfunction

  function automatic logic [15:0] grp_of(input logic [127:0] a, input logic [2:0] g);
    return a[(3'd7 - g) * 16 +: 16];
  endfunction

  // The next address is loaded in the cycle that registers the last character,
  // so texts leave back to back.
  assign adv    = !out_valid_r || !out_stall;
  assign pop    = !q_empty && (!busy_r || (adv && !busy_nxt));
  assign grp    = grp_of(ent_r.addr, g_r);
  assign nib    = grp[(2'd3 - n_r) * 4 +: 4];
  assign g_inc  = g_r + 3'd1;
  assign hi_inc = ent_r.run_hi + 3'd1;

  always_comb begin
    ph_nxt       = ph_r;
    g_nxt        = g_r;
    n_nxt        = n_r;
    busy_nxt     = busy_r;
    out_data_nxt.char_code = CHR_COLON;
    out_data_nxt.last_char = 1'b0;
    unique case (ph_r)
      PH_DC1: begin
        ph_nxt = PH_DC2;
      end
      PH_DC2: begin
        if (ent_r.run_hi == 3'd7) begin
          out_data_nxt.last_char = 1'b1;
          busy_nxt = 1'b0;
        end else begin
          g_nxt  = hi_inc;
          n_nxt  = first_nib(grp_of(ent_r.addr, hi_inc));
          ph_nxt = PH_DIG;
        end
      end
      PH_DIG: begin
        out_data_nxt.char_code = (nib < 4'd10) ? CHR_ZERO + 7'(nib)
                                               : CHR_A + 7'(nib) - 7'd10;
        if (n_r == 2'd3) begin
          if (g_r == 3'd7) begin
            out_data_nxt.last_char = 1'b1;
            busy_nxt = 1'b0;
          end else begin
            ph_nxt = PH_COL;
          end
        end else begin
          n_nxt = n_r + 2'd1;
        end
      end
      PH_COL: begin
        g_nxt = g_inc;
        if (ent_r.has_run && g_inc == ent_r.run_lo) begin
          ph_nxt = PH_DC2;
        end else begin
          n_nxt  = first_nib(grp_of(ent_r.addr, g_inc));
          ph_nxt = PH_DIG;
        end
      end
      default: begin
        ph_nxt = PH_DIG;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      ph_r        <= PH_DIG;
      g_r         <= 3'd0;
      n_r         <= 2'd0;
    end else begin
      if (pop) begin
        ent_r  <= pop_entry;
        busy_r <= 1'b1;
        g_r    <= 3'd0;
        n_r    <= first_nib(grp_of(pop_entry.addr, 3'd0));
        ph_r   <= (pop_entry.has_run && pop_entry.run_lo == 3'd0) ? PH_DC1 : PH_DIG;
      end else if (busy_r && adv) begin
        busy_r <= busy_nxt;
        g_r    <= g_nxt;
        n_r    <= n_nxt;
        ph_r   <= ph_nxt;
      end
      if (adv) begin
        out_valid_r <= busy_r;
        if (busy_r) begin
          out_data_r <= out_data_nxt;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/ipv6_address_text_compressor.sv =====
// ----------------------------------------------------------------------------
// IPv6 address text compressor
// Turns 128-bit addresses into their shortest text form, one char a transfer.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one address per transfer as two 64-bit halves.
// The front end classifies it in the same cycle and writes it into a
// two-entry queue; in_stall is high only while that queue is full.
// The back end takes one queued address and produces one character per
// cycle while out_stall is low, through an output register, with last_char
// set on the final character. The next queued address is loaded in the cycle
// that sends the last character, so texts leave back to back; a text has
// 2 to 39 characters.
// From input transfer to first output character an address passes the queue,
// the back end's entry register and the output register.
// When out_stall is high the current character holds and the sequencer
// waits; the queue keeps accepting until it is full.
// Reset empties the queue and the output register; no item is lost once
// transferred, and none is produced until one arrives.
// ----------------------------------------------------------------------------
module ipv6_address_text_compressor import ipv6tc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_data_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_data_t out_data
);

  logic   q_full;
  logic   q_empty;
  logic   push;
  logic   pop;
  entry_t push_entry;
  entry_t pop_entry;

  ipv6tc_front u_front (
    .in_valid   (in_valid),
    .in_data    (in_data),
    .q_full     (q_full),
    .in_stall   (in_stall),
    .push       (push),
    .push_entry (push_entry)
  );

  ipv6tc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_full     (q_full),
    .q_empty    (q_empty)
  );

  ipv6tc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .pop_entry (pop_entry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("queue reports full and empty at once");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.char_code >= CHR_ZERO && out_data.char_code <= 7'd102))
    else $error("character code out of range");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("pop from empty queue");
`endif

endmodule
